[rtl/ffcr_pkg.sv]
package ffcr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned CMD_W     = 32;
    localparam int unsigned OPT_W     = 24;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned PWM_W     = 16;
    localparam int unsigned PAYLOAD_W = CMD_W + OPT_W + DATA_W;

    // Frame byte positions (input and reply share the same layout)
    localparam logic [POS_W-1:0] POS_START    = 5'd0;
    localparam logic [POS_W-1:0] POS_CMD_LAST = 5'd4;
    localparam logic [POS_W-1:0] POS_OPT_LAST = 5'd7;
    localparam logic [POS_W-1:0] POS_DAT_LAST = 5'd15;
    localparam logic [POS_W-1:0] POS_ACK      = 5'd16;
    localparam logic [POS_W-1:0] POS_END      = 5'd17;

    localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;
    localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;

    localparam logic [CMD_W-1:0] CMD_MOVL = "MOVL";
    localparam logic [CMD_W-1:0] CMD_GPOS = "GPOS";
    localparam logic [CMD_W-1:0] CMD_GVEL = "GVEL";
    localparam logic [CMD_W-1:0] CMD_GSTT = "GSTT";
    localparam logic [CMD_W-1:0] CMD_GCUS = "GCUS";
    localparam logic [CMD_W-1:0] CMD_GTIM = "GTIM";
    localparam logic [CMD_W-1:0] CMD_DLED = "DLED";
    localparam logic [CMD_W-1:0] CMD_ALED = "ALED";
    localparam logic [CMD_W-1:0] CMD_NULL = "NULL";

    // LED data literals, zero padded to eight bytes
    localparam logic [DATA_W-1:0] DATA_LED_ON  = {"LED-ON", 16'h0000};
    localparam logic [DATA_W-1:0] DATA_LED_OFF = {"LED-OFF", 8'h00};

    // ASCII offset folded over the three digit weights: 48 * 111
    localparam logic [PWM_W-1:0] PWM_ASCII_OFS = 16'd5328;

    function automatic logic is_known_cmd(input logic [CMD_W-1:0] cmd);
        return (cmd == CMD_MOVL) || (cmd == CMD_GPOS) || (cmd == CMD_GVEL) ||
               (cmd == CMD_GSTT) || (cmd == CMD_GCUS) || (cmd == CMD_GTIM) ||
               (cmd == CMD_DLED) || (cmd == CMD_ALED);
    endfunction

endpackage

[rtl/fixed_frame_command_responder_core.sv]
// Channel  Dir  Ports                                           Moves per transfer
// s_       in   s_valid s_ready s_rx_byte                       one received byte
// m_       out  m_valid m_ready m_tx_byte m_last_of_reply       one reply byte
//               m_led_pin_level m_pwm_compare
//
// One input byte per cycle. Bytes are grouped into 18-byte frames counted from reset.
// The closing byte of a valid frame loads the reply register; the 18 reply bytes follow
// on m_, one per cycle while m_ready is high, from the cycle after that byte is taken.
// Input stalls only on a frame's closing byte while the previous reply is still
// draining (other than its final transfer), since the reply register is single.
// aresetn is synchronous, active low: frame position, LED level and PWM value clear.
module fixed_frame_command_responder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ffcr_pkg::BYTE_W-1:0]        s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ffcr_pkg::BYTE_W-1:0]        m_tx_byte,
    output logic                               m_last_of_reply,
    output logic                               m_led_pin_level,
    output logic signed [ffcr_pkg::PWM_W-1:0]  m_pwm_compare
);

    // ---------------- frame capture (input side) ----------------
    logic [ffcr_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        stx_seen_reg, stx_seen_next;
    logic [ffcr_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ffcr_pkg::OPT_W-1:0]  opt_reg, opt_next;
    logic [ffcr_pkg::DATA_W-1:0] data_reg, data_next;

    // ---------------- reply side ----------------
    logic                           busy_reg, busy_next;
    logic [ffcr_pkg::POS_W-1:0]     out_pos_reg, out_pos_next;
    logic [ffcr_pkg::PAYLOAD_W-1:0] shift_reg, shift_next;
    logic                           led_reg, led_next;
    logic [ffcr_pkg::PWM_W-1:0]     pwm_reg, pwm_next;

    logic s_xfer, m_xfer, end_byte, frame_ok, reply_last;
    logic [ffcr_pkg::CMD_W-1:0] reply_cmd;
    logic [ffcr_pkg::PWM_W-1:0] d0_w, d1_w, d2_w, pwm_calc;

    assign reply_last = (out_pos_reg == ffcr_pkg::POS_END);
    assign m_xfer     = m_valid && m_ready;
    assign end_byte   = (pos_reg == ffcr_pkg::POS_END);
    // Closing byte can enter if the reply register is free or frees at this edge
    assign s_ready    = !(end_byte && busy_reg && !(m_xfer && reply_last));
    assign s_xfer     = s_valid && s_ready;
    assign frame_ok   = s_xfer && end_byte && stx_seen_reg && (s_rx_byte == ffcr_pkg::CH_ETX);

    assign reply_cmd = ffcr_pkg::is_known_cmd(cmd_reg) ? cmd_reg : ffcr_pkg::CMD_NULL;

    // ALED: three unchecked ASCII digits, wraps to 16 bits
    assign d0_w     = {8'h00, data_reg[63:56]};
    assign d1_w     = {8'h00, data_reg[55:48]};
    assign d2_w     = {8'h00, data_reg[47:40]};
    assign pwm_calc = 16'(d0_w * 16'd100) + 16'(d1_w * 16'd10) + d2_w
                      - ffcr_pkg::PWM_ASCII_OFS;

    always_comb begin
        pos_next      = pos_reg;
        stx_seen_next = stx_seen_reg;
        cmd_next      = cmd_reg;
        opt_next      = opt_reg;
        data_next     = data_reg;
        if (s_xfer) begin
            if (pos_reg == ffcr_pkg::POS_START) begin
                stx_seen_next = (s_rx_byte == ffcr_pkg::CH_STX);
            end else if (pos_reg <= ffcr_pkg::POS_CMD_LAST) begin
                cmd_next = {cmd_reg[ffcr_pkg::CMD_W-9:0], s_rx_byte};
            end else if (pos_reg <= ffcr_pkg::POS_OPT_LAST) begin
                opt_next = {opt_reg[ffcr_pkg::OPT_W-9:0], s_rx_byte};
            end else if (pos_reg <= ffcr_pkg::POS_DAT_LAST) begin
                data_next = {data_reg[ffcr_pkg::DATA_W-9:0], s_rx_byte};
            end
            pos_next = end_byte ? ffcr_pkg::POS_START : pos_reg + 5'd1;
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        out_pos_next = out_pos_reg;
        shift_next   = shift_reg;
        led_next     = led_reg;
        pwm_next     = pwm_reg;
        if (m_xfer) begin
            if (reply_last) begin
                busy_next    = 1'b0;
                out_pos_next = ffcr_pkg::POS_START;
            end else begin
                out_pos_next = out_pos_reg + 5'd1;
            end
            // Middle bytes come off the top of the shift register
            if ((out_pos_reg != ffcr_pkg::POS_START) && (out_pos_reg <= ffcr_pkg::POS_DAT_LAST)) begin
                shift_next = {shift_reg[ffcr_pkg::PAYLOAD_W-9:0], 8'h00};
            end
        end
        if (frame_ok) begin
            busy_next    = 1'b1;
            out_pos_next = ffcr_pkg::POS_START;
            shift_next   = {reply_cmd, opt_reg, data_reg};
            if (cmd_reg == ffcr_pkg::CMD_DLED) begin
                if (data_reg == ffcr_pkg::DATA_LED_ON) begin
                    led_next = 1'b0;
                end else if (data_reg == ffcr_pkg::DATA_LED_OFF) begin
                    led_next = 1'b1;
                end
            end else if (cmd_reg == ffcr_pkg::CMD_ALED) begin
                pwm_next = pwm_calc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= ffcr_pkg::POS_START;
            stx_seen_reg <= 1'b0;
            busy_reg     <= 1'b0;
            out_pos_reg  <= ffcr_pkg::POS_START;
            led_reg      <= 1'b0;
            pwm_reg      <= '0;
        end else begin
            pos_reg      <= pos_next;
            stx_seen_reg <= stx_seen_next;
            busy_reg     <= busy_next;
            out_pos_reg  <= out_pos_next;
            led_reg      <= led_next;
            pwm_reg      <= pwm_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        opt_reg   <= opt_next;
        data_reg  <= data_next;
        shift_reg <= shift_next;
    end

    // ---------------- output ----------------
    always_comb begin
        priority if (out_pos_reg == ffcr_pkg::POS_START) begin
            m_tx_byte = ffcr_pkg::CH_STX;
        end else if (out_pos_reg == ffcr_pkg::POS_ACK) begin
            m_tx_byte = ffcr_pkg::CH_ACK;
        end else if (out_pos_reg == ffcr_pkg::POS_END) begin
            m_tx_byte = ffcr_pkg::CH_ETX;
        end else begin
            m_tx_byte = shift_reg[ffcr_pkg::PAYLOAD_W-1 -: 8];
        end
    end

    assign m_valid         = busy_reg;
    assign m_last_of_reply = reply_last;
    assign m_led_pin_level = led_reg;
    assign m_pwm_compare   = signed'(pwm_reg);

    // ---------------- assertions ----------------
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= ffcr_pkg::POS_END)
        else $error("frame position out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_ok |-> (!busy_reg || (m_xfer && reply_last)))
        else $error("reply register overwritten while draining");

    a_reply_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_ok |=> (m_valid && (m_tx_byte == ffcr_pkg::CH_STX) && !m_last_of_reply))
        else $error("reply does not open with STX");

    a_pwm_only_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && $past(aresetn) && !$stable(pwm_reg)) |-> $past(frame_ok))
        else $error("PWM value changed without a valid frame");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [ffcr_pkg::BYTE_W-1:0]        tx_byte;
        logic                               last_of_reply;
        logic                               led_pin_level;
        logic signed [ffcr_pkg::PWM_W-1:0]  pwm_compare;
    } reply_byte_t;

    localparam int FRAME_BYTES = 18;
    localparam int FRAME_W     = FRAME_BYTES * ffcr_pkg::BYTE_W;

    localparam logic [ffcr_pkg::CMD_W-1:0] KNOWN_CMDS [8] = '{
        ffcr_pkg::CMD_MOVL, ffcr_pkg::CMD_GPOS, ffcr_pkg::CMD_GVEL, ffcr_pkg::CMD_GSTT,
        ffcr_pkg::CMD_GCUS, ffcr_pkg::CMD_GTIM, ffcr_pkg::CMD_DLED, ffcr_pkg::CMD_ALED
    };
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_FRAMES = 1;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [ffcr_pkg::BYTE_W-1:0]         s_rx_byte = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [ffcr_pkg::BYTE_W-1:0]         m_tx_byte;
    logic                                m_last_of_reply;
    logic                                m_led_pin_level;
    logic signed [ffcr_pkg::PWM_W-1:0]   m_pwm_compare;

    // Framing state mirrored from the byte stream
    logic [ffcr_pkg::POS_W-1:0]          frame_pos = ffcr_pkg::POS_START;
    logic                                frame_started = 1'b0;
    logic [ffcr_pkg::CMD_W-1:0]          frame_cmd = '0;
    logic [ffcr_pkg::OPT_W-1:0]          frame_opt = '0;
    logic [ffcr_pkg::DATA_W-1:0]         frame_data = '0;
    logic                                led_level = 1'b0;
    logic signed [ffcr_pkg::PWM_W-1:0]   pwm_level = '0;

    reply_byte_t                         pending_reply[$];
    reply_byte_t                         want;

    // Stall control: steady turns off idling on both sides; a new hold request
    // makes the receiver hold m_ready low, counting hold_left down from HOLD_CYCLES
    bit                                  steady = 1'b0;
    int                                  hold_requests = 0;
    int                                  holds_served = 0;
    int                                  hold_left = 0;

    int                                  errors = 0;
    int                                  bytes_sent = 0;
    int                                  frames_sent = 0;
    int                                  replies_due = 0;
    int                                  reply_bytes_seen = 0;

    fixed_frame_command_responder_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_byte       (m_tx_byte),
        .m_last_of_reply (m_last_of_reply),
        .m_led_pin_level (m_led_pin_level),
        .m_pwm_compare   (m_pwm_compare)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Tracks frame position and field capture for one accepted byte; on the
    // closing byte of a valid frame, applies DLED/ALED effects and queues the
    // 18 reply bytes.
    function automatic void absorb_rx_byte(input logic [ffcr_pkg::BYTE_W-1:0] b);
        logic [ffcr_pkg::CMD_W-1:0]   echo_cmd;
        logic [FRAME_W-1:0]           image;
        int signed                    duty;
        reply_byte_t                  rb;
        if (frame_pos == ffcr_pkg::POS_START) begin
            frame_started = (b == ffcr_pkg::CH_STX);
        end else if (frame_pos <= ffcr_pkg::POS_CMD_LAST) begin
            frame_cmd = {frame_cmd[ffcr_pkg::CMD_W-ffcr_pkg::BYTE_W-1:0], b};
        end else if (frame_pos <= ffcr_pkg::POS_OPT_LAST) begin
            frame_opt = {frame_opt[ffcr_pkg::OPT_W-ffcr_pkg::BYTE_W-1:0], b};
        end else if (frame_pos <= ffcr_pkg::POS_DAT_LAST) begin
            frame_data = {frame_data[ffcr_pkg::DATA_W-ffcr_pkg::BYTE_W-1:0], b};
        end
        if (frame_pos != ffcr_pkg::POS_END) begin
            frame_pos = frame_pos + 5'd1;
            return;
        end
        frame_pos = ffcr_pkg::POS_START;
        if (!(frame_started && b == ffcr_pkg::CH_ETX))
            return;

        echo_cmd = (frame_cmd inside {ffcr_pkg::CMD_MOVL, ffcr_pkg::CMD_GPOS,
                                      ffcr_pkg::CMD_GVEL, ffcr_pkg::CMD_GSTT,
                                      ffcr_pkg::CMD_GCUS, ffcr_pkg::CMD_GTIM,
                                      ffcr_pkg::CMD_DLED, ffcr_pkg::CMD_ALED})
                   ? frame_cmd : ffcr_pkg::CMD_NULL;
        if (frame_cmd == ffcr_pkg::CMD_DLED) begin
            if (frame_data == {"LED-ON", 16'h0000})
                led_level = 1'b0;
            else if (frame_data == {"LED-OFF", 8'h00})
                led_level = 1'b1;
        end else if (frame_cmd == ffcr_pkg::CMD_ALED) begin
            // digits are taken as-is, no range check
            duty = 100 * (int'(frame_data[63:56]) - 48)
                 + 10 * (int'(frame_data[55:48]) - 48)
                 + (int'(frame_data[47:40]) - 48);
            pwm_level = duty[ffcr_pkg::PWM_W-1:0];
        end

        image = {ffcr_pkg::CH_STX, echo_cmd, frame_opt, frame_data,
                 ffcr_pkg::CH_ACK, ffcr_pkg::CH_ETX};
        for (int i = 0; i < FRAME_BYTES; i++) begin
            rb.tx_byte       = image[FRAME_W-1-ffcr_pkg::BYTE_W*i -: ffcr_pkg::BYTE_W];
            rb.last_of_reply = (i == FRAME_BYTES - 1);
            rb.led_pin_level = led_level;
            rb.pwm_compare   = pwm_level;
            pending_reply.push_back(rb);
        end
        replies_due++;
    endfunction

    // One transfer on s_; valid stays up between back-to-back bytes
    task automatic send_byte(input logic [ffcr_pkg::BYTE_W-1:0] b);
        while (!steady && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [ffcr_pkg::BYTE_W-1:0] first,
                              input logic [ffcr_pkg::CMD_W-1:0] cmd,
                              input logic [ffcr_pkg::OPT_W-1:0] opt,
                              input logic [ffcr_pkg::DATA_W-1:0] data,
                              input logic [ffcr_pkg::BYTE_W-1:0] last);
        logic [FRAME_W-1:0] image;
        image = {first, cmd, opt, data, 8'($urandom_range(255)), last};
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(image[FRAME_W-1-ffcr_pkg::BYTE_W*i -: ffcr_pkg::BYTE_W]);
        frames_sent++;
    endtask

    function automatic logic [ffcr_pkg::DATA_W-1:0] digit_data(input int d0, input int d1,
                                                               input int d2);
        return {8'(d0), 8'(d1), 8'(d2), 8'($urandom), 32'($urandom)};
    endfunction

    // Receiver: random stalls unless steady, or a counted hold-off when requested
    always @(posedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 10);
        end
    end

    // Reply checker: each m_ transfer against the oldest expected byte
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reply_bytes_seen++;
            if (pending_reply.size() == 0) begin
                $error("reply transfer with nothing expected: tx_byte=%h", m_tx_byte);
                errors++;
            end else begin
                want = pending_reply.pop_front();
                if (m_tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %h, actual %h", want.tx_byte, m_tx_byte);
                    errors++;
                end
                if (m_last_of_reply !== want.last_of_reply) begin
                    $error("last_of_reply: expected %b, actual %b",
                           want.last_of_reply, m_last_of_reply);
                    errors++;
                end
                if (m_led_pin_level !== want.led_pin_level) begin
                    $error("led_pin_level: expected %b, actual %b",
                           want.led_pin_level, m_led_pin_level);
                    errors++;
                end
                if (m_pwm_compare !== want.pwm_compare) begin
                    $error("pwm_compare: expected %0d, actual %0d",
                           want.pwm_compare, m_pwm_compare);
                    errors++;
                end
            end
        end
    end

    // Unknown command comes back as NULL
    task automatic test_unknown_command();
        send_frame(ffcr_pkg::CH_STX, "DLEE", 24'h123456, 64'h0123_4567_89AB_CDEF,
                   ffcr_pkg::CH_ETX);
    endtask

    // LED pin: OFF moves it away from its reset level
    task automatic test_led_commands();
        send_frame(ffcr_pkg::CH_STX, ffcr_pkg::CMD_DLED, 24'h0, {"LED-OFF", 8'h00},
                   ffcr_pkg::CH_ETX);
    endtask

    // PWM value: the unchecked top extreme
    task automatic test_pwm_digits();
        send_frame(ffcr_pkg::CH_STX, ffcr_pkg::CMD_ALED, 24'h0,
                   digit_data(8'hFF, 8'hFF, 8'hFF), ffcr_pkg::CH_ETX);
    endtask

    // A frame with a bad opening byte draws no reply and leaves state alone
    task automatic test_broken_frames();
        send_frame(ffcr_pkg::CH_ETX, ffcr_pkg::CMD_ALED, 24'h0, digit_data("5", "5", "5"),
                   ffcr_pkg::CH_ETX);
    endtask

    // Receiver stops for a long stretch while frames keep coming, so the
    // closing byte of the second frame must stall on s_
    task automatic test_reply_backpressure();
        hold_requests++;
        steady = 1'b1;
        for (int i = 0; i < 2; i++)
            send_frame(ffcr_pkg::CH_STX, KNOWN_CMDS[$urandom_range(7)], 24'($urandom),
                       {$urandom, $urandom}, ffcr_pkg::CH_ETX);
        steady = 1'b0;
    endtask

    // Random content with no idling on either side; sometimes a broken frame
    task automatic test_random_traffic();
        int                           kind;
        logic [ffcr_pkg::BYTE_W-1:0]  first;
        logic [ffcr_pkg::BYTE_W-1:0]  last;
        logic [ffcr_pkg::CMD_W-1:0]   cmd;
        logic [ffcr_pkg::DATA_W-1:0]  data;
        steady = 1'b1;
        for (int n = 0; n < RANDOM_FRAMES; n++) begin
            kind = $urandom_range(99);
            cmd  = ($urandom_range(3) == 0) ? $urandom : KNOWN_CMDS[$urandom_range(7)];
            data = {$urandom, $urandom};
            if (cmd == ffcr_pkg::CMD_DLED && $urandom_range(1))
                data = $urandom_range(1) ? {"LED-ON", 16'h0000} : {"LED-OFF", 8'h00};
            else if (cmd == ffcr_pkg::CMD_ALED && $urandom_range(3) != 0)
                data = digit_data("0" + $urandom_range(9), "0" + $urandom_range(9),
                                  "0" + $urandom_range(9));
            first = ffcr_pkg::CH_STX;
            last  = ffcr_pkg::CH_ETX;
            if (kind < 8)
                first = 8'($urandom_range(255));
            else if (kind < 16)
                last = 8'($urandom_range(255));
            send_frame(first, cmd, 24'($urandom), data, last);
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unknown_command();
        test_led_commands();
        test_pwm_digits();
        test_broken_frames();
        test_reply_backpressure();
        test_random_traffic();

        s_valid <= 1'b0;
        while (pending_reply.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d frames; %0d answered, %0d reply bytes checked.",
                 bytes_sent, frames_sent, replies_due, reply_bytes_seen);
        $display("Covered NULL echo, LED and PWM updates, a broken frame and a long stall.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
